[design/eulr_pkg.sv]
// package: types, constants and tables for the euler rotation matrix block
package eulr_pkg;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [23:0] vec_x;
    logic signed [23:0] vec_y;
    logic signed [23:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] rot_x;
    logic signed [23:0] rot_y;
    logic signed [23:0] rot_z;
    logic               saturated;
  } out_item_t;

  localparam logic KIND_ANGLES = 1'b0;
  localparam logic KIND_ROTATE = 1'b1;

  localparam int TABLE_LEN = 24;
  localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

  // cordic request/response between top level and the cordic unit
  typedef struct packed {
    logic               start;
    logic signed [15:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [16:0] sin_q15;
    logic signed [16:0] cos_q15;
  } cordic_rsp_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  atan_q30 = 32'sd843314857;
      5'd1:  atan_q30 = 32'sd497837829;
      5'd2:  atan_q30 = 32'sd263043837;
      5'd3:  atan_q30 = 32'sd133525159;
      5'd4:  atan_q30 = 32'sd67021687;
      5'd5:  atan_q30 = 32'sd33543516;
      5'd6:  atan_q30 = 32'sd16775851;
      5'd7:  atan_q30 = 32'sd8388437;
      5'd8:  atan_q30 = 32'sd4194283;
      5'd9:  atan_q30 = 32'sd2097149;
      5'd10: atan_q30 = 32'sd1048576;
      5'd11: atan_q30 = 32'sd524288;
      5'd12: atan_q30 = 32'sd262144;
      5'd13: atan_q30 = 32'sd131072;
      5'd14: atan_q30 = 32'sd65536;
      5'd15: atan_q30 = 32'sd32768;
      5'd16: atan_q30 = 32'sd16384;
      5'd17: atan_q30 = 32'sd8192;
      5'd18: atan_q30 = 32'sd4096;
      5'd19: atan_q30 = 32'sd2048;
      5'd20: atan_q30 = 32'sd1024;
      5'd21: atan_q30 = 32'sd512;
      5'd22: atan_q30 = 32'sd256;
      5'd23: atan_q30 = 32'sd128;
      default: atan_q30 = 32'sd0;
    endcase
  endfunction

endpackage

[design/eulr_cordic.sv]
// iterative cordic: one micro-rotation per cycle, sine and cosine in q2.15
module eulr_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  eulr_pkg::cordic_req_t req,
  output eulr_pkg::cordic_rsp_t rsp
);
  localparam int STEPS = (CORDIC_STEPS < eulr_pkg::TABLE_LEN) ?
                         CORDIC_STEPS : eulr_pkg::TABLE_LEN;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [4:0]         step_r, step_nxt;
  logic               neg_r, neg_nxt;
  logic signed [35:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [16:0] s_r, s_nxt, c_r, c_nxt;

  logic signed [35:0] a_w, xs, ys, xf, yf, xr, yr;

  function automatic logic signed [16:0] rnd(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + 36'sd16384) >>> 15;
    if (t > 36'sd65535) rnd = 17'sd65535;
    else if (t < -36'sd65536) rnd = -17'sd65536;
    else rnd = t[16:0];
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    s_nxt = s_r; c_nxt = c_r;
    a_w = 36'(req.angle) <<< 17;
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    xf = neg_r ? -x_r : x_r;
    yf = neg_r ? -y_r : y_r;
    xr = '0; yr = '0;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      x_nxt = eulr_pkg::GAIN_Q30;
      y_nxt = '0;
      neg_nxt = 1'b0;
      z_nxt = a_w;
      // reduce into a quarter turn by a half-turn shift, which negates both outputs
      if (a_w > eulr_pkg::HALF_PI_Q30) begin
        z_nxt = a_w - eulr_pkg::PI_Q30; neg_nxt = 1'b1;
      end else if (a_w < -eulr_pkg::HALF_PI_Q30) begin
        z_nxt = a_w + eulr_pkg::PI_Q30; neg_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (step_r == 5'(STEPS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        c_nxt = rnd(xf);
        s_nxt = rnd(yf);
      end else begin
        if (z_r >= 0) begin
          xr = x_r - ys; yr = y_r + xs;
          z_nxt = z_r - 36'(eulr_pkg::atan_q30(step_r));
        end else begin
          xr = x_r + ys; yr = y_r - xs;
          z_nxt = z_r + 36'(eulr_pkg::atan_q30(step_r));
        end
        x_nxt = xr; y_nxt = yr;
        step_nxt = step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    neg_r <= neg_nxt;
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    s_r <= s_nxt; c_r <= c_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.sin_q15 = s_r;
  assign rsp.cos_q15 = c_r;
endmodule

[design/euler_rotation_matrix_transform.sv]
// top level: zyx rotation matrix build and matrix-vector rotate, one shared multiplier
//
//  channel | ports                      | payload
//  in      | in_valid, in_stall, in_data  | eulr_pkg::in_item_t
//  out     | out_valid, out_stall, out_data | eulr_pkg::out_item_t
//
// angle beat: three cordic runs, roll, pitch and yaw in turn, then the matrix entries
//   are built on the shared 17x34 multiplier; the next beat is accepted only after that
// rotate beat: the entry-by-component products are summed per row on the same multiplier,
//   then the result is registered in S_OUT; the next beat is accepted only after that
// input is stalled while a beat is in work; a waiting result only blocks a rotate finish
// synchronous reset clears the matrix to zero and the sequencer to idle
module euler_rotation_matrix_transform #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  eulr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output eulr_pkg::out_item_t out_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_COR, S_MUL, S_ROT, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0] ang_r;          // which angle in cordic
  logic [3:0] op_r;           // multiply step
  logic [1:0] col_r;          // column within a rotate row
  logic signed [16:0] sr_r, cr_r, sp_r, cp_r, sy_r, cy_r;
  logic signed [16:0] m_r [9];
  logic signed [23:0] v_r [3];
  logic signed [47:0] acc_r;  // q.45 partial sum of an entry, or q.15 sum of a rotate row
  logic signed [33:0] t_r;    // two-factor product
  logic row_r;
  logic sat_r;
  logic signed [23:0] res_r [2];
  logic out_valid_r;
  eulr_pkg::out_item_t out_r;
  eulr_pkg::in_item_t in_r;

  eulr_pkg::cordic_req_t creq;
  eulr_pkg::cordic_rsp_t crsp;
  logic cstart_r;

  eulr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  always_comb begin
    creq.start = cstart_r;
    case (ang_r)
      2'd0:    creq.angle = in_r.roll;
      2'd1:    creq.angle = in_r.pitch;
      default: creq.angle = in_r.yaw;
    endcase
  end

  // shared multiplier operands
  logic signed [16:0] ma;
  logic signed [33:0] mb;
  logic signed [50:0] prod;
  always_comb begin
    ma = '0; mb = '0;
    if (state_r == S_MUL) begin
      case (op_r)
        4'd0:  begin ma = cp_r; mb = 34'(cy_r); end
        4'd1:  begin ma = sr_r; mb = 34'(cy_r); end
        4'd2:  begin ma = sp_r; mb = t_r; end
        4'd3:  begin ma = cr_r; mb = 34'(sy_r); end
        4'd4:  begin ma = cr_r; mb = 34'(cy_r); end
        4'd5:  begin ma = sp_r; mb = t_r; end
        4'd6:  begin ma = sr_r; mb = 34'(sy_r); end
        4'd7:  begin ma = cp_r; mb = 34'(sy_r); end
        4'd8:  begin ma = sr_r; mb = 34'(sp_r); end
        4'd9:  begin ma = sy_r; mb = t_r; end
        4'd10: begin ma = cr_r; mb = 34'(cy_r); end
        4'd11: begin ma = cr_r; mb = 34'(sp_r); end
        4'd12: begin ma = sy_r; mb = t_r; end
        4'd13: begin ma = cy_r; mb = 34'(sr_r); end
        4'd14: begin ma = cp_r; mb = 34'(sr_r); end
        default: begin ma = cr_r; mb = 34'(cp_r); end
      endcase
    end else if (op_r < 4'd9) begin
      ma = m_r[op_r];
      mb = 34'(v_r[col_r]);
    end
    prod = 51'(ma) * 51'(mb);
  end

  function automatic logic signed [16:0] to_entry(input logic signed [50:0] q);
    logic signed [50:0] t;
    t = (q + 51'sd536870912) >>> 30;
    if (t > 51'sd65535) to_entry = 17'sd65535;
    else if (t < -51'sd65536) to_entry = -17'sd65536;
    else to_entry = t[16:0];
  endfunction

  logic signed [50:0] p45;    // two-factor product moved to q.45
  assign p45 = prod <<< 15;

  logic signed [47:0] rnd_row;
  logic row_hi, row_lo;
  assign rnd_row = (acc_r + 48'sd16384) >>> 15;
  assign row_hi = rnd_row > 48'sd8388607;
  assign row_lo = rnd_row < -48'sd8388608;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cstart_r <= 1'b0;
      out_valid_r <= 1'b0;
      ang_r <= '0;
      op_r <= '0;
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < 9; i++) m_r[i] <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          cstart_r <= in_valid && (in_data.kind == eulr_pkg::KIND_ANGLES);
          if (in_valid) begin
            in_r <= in_data;
            v_r[0] <= in_data.vec_x;
            v_r[1] <= in_data.vec_y;
            v_r[2] <= in_data.vec_z;
            op_r <= '0; col_r <= '0; row_r <= '0; acc_r <= '0; sat_r <= 1'b0;
            if (in_data.kind == eulr_pkg::KIND_ANGLES) begin
              ang_r <= '0; state_r <= S_COR;
            end else begin
              state_r <= S_ROT;
            end
          end
        end
        S_COR: begin
          cstart_r <= crsp.done && (ang_r != 2'd2);
          if (crsp.done) begin
            case (ang_r)
              2'd0: begin sr_r <= crsp.sin_q15; cr_r <= crsp.cos_q15; end
              2'd1: begin sp_r <= crsp.sin_q15; cp_r <= crsp.cos_q15; end
              default: begin sy_r <= crsp.sin_q15; cy_r <= crsp.cos_q15; end
            endcase
            if (ang_r == 2'd2) begin
              op_r <= '0; acc_r <= '0; state_r <= S_MUL;
            end else begin
              ang_r <= ang_r + 2'd1;
            end
          end
        end
        S_MUL: begin
          cstart_r <= 1'b0;
          op_r <= op_r + 4'd1;
          case (op_r)
            4'd0:  m_r[0] <= to_entry(p45);
            4'd1:  t_r <= prod[33:0];
            4'd2:  acc_r <= prod[47:0];
            4'd3:  m_r[1] <= to_entry(51'(acc_r) - p45);
            4'd4:  t_r <= prod[33:0];
            4'd5:  acc_r <= prod[47:0];
            4'd6:  m_r[2] <= to_entry(51'(acc_r) + p45);
            4'd7:  m_r[3] <= to_entry(p45);
            4'd8:  t_r <= prod[33:0];
            4'd9:  acc_r <= prod[47:0];
            4'd10: m_r[4] <= to_entry(51'(acc_r) + p45);
            4'd11: t_r <= prod[33:0];
            4'd12: acc_r <= prod[47:0];
            4'd13: m_r[5] <= to_entry(51'(acc_r) - p45);
            4'd14: m_r[7] <= to_entry(p45);
            default: begin
              m_r[8] <= to_entry(p45);
              m_r[6] <= (sp_r == -17'sd65536) ? 17'sd65535 : -sp_r;
              state_r <= S_IDLE;
            end
          endcase
        end
        S_ROT: begin
          cstart_r <= 1'b0;
          // op_r walks entries 0..8, col_r the column, three per row
          if (op_r == 4'd9) begin
            state_r <= S_OUT;
          end else begin
            op_r <= op_r + 4'd1;
            col_r <= (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
            if (col_r == 2'd0) acc_r <= prod[47:0];
            else acc_r <= acc_r + prod[47:0];
            if (col_r == 2'd0 && op_r != 4'd0) begin
              res_r[row_r] <= row_hi ? 24'sd8388607 : row_lo ? -24'sd8388608 :
                              rnd_row[23:0];
              sat_r <= sat_r | row_hi | row_lo;
              row_r <= row_r + 1'b1;
            end
          end
        end
        default: begin
          cstart_r <= 1'b0;
          if (!out_valid_r || !out_stall) begin
            out_r.rot_x <= res_r[0];
            out_r.rot_y <= res_r[1];
            out_r.rot_z <= row_hi ? 24'sd8388607 : row_lo ? -24'sd8388608 : rnd_row[23:0];
            out_r.saturated <= sat_r | row_hi | row_lo;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_rot_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !(out_valid_r && out_stall)) |=> out_valid)
    else $error("rotate finish gave no result");
  a_angle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> !$rose(out_valid))
    else $error("angle beat produced a result");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COR) |-> in_stall)
    else $error("input open during cordic");
`endif
endmodule

[bench/euler_rotation_matrix_transform_test.sv]
// testbench: zyx rotation matrix block against an in-bench fixed-point predictor
module euler_rotation_matrix_transform_test;

  localparam int STEPS = 16;
  localparam longint LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  eulr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  eulr_pkg::out_item_t out_data;

  euler_rotation_matrix_transform #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  eulr_pkg::in_item_t pending_beats[$];
  eulr_pkg::out_item_t expected_rotations[$];
  longint matrix[9];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_on = 1'b0;
  bit in_taken = 1'b0;
  int errors = 0;
  longint cycle_count = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536,
      32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  task automatic cordic_sin_cos(input logic signed [15:0] ang, output longint s,
                                output longint c);
    longint a, x, y, t;
    bit neg;
    a = longint'(ang) * 131072;
    neg = 1'b0;
    x = 652032874;
    y = 0;
    if (a > 1686629713) begin
      a -= 64'sd3373259426; neg = 1'b1;
    end else if (a < -1686629713) begin
      a += 64'sd3373259426; neg = 1'b1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (a >= 0) begin
        t = x - floor_shr(y, i); y = y + floor_shr(x, i); a -= atan_step(i);
      end else begin
        t = x + floor_shr(y, i); y = y - floor_shr(x, i); a += atan_step(i);
      end
      x = t;
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = clip(floor_shr(x + 16384, 15), -65536, 65535);
    s = clip(floor_shr(y + 16384, 15), -65536, 65535);
  endtask

  function automatic longint round_entry(longint q45);
    return clip(floor_shr(q45 + (longint'(1) << 29), 30), -65536, 65535);
  endfunction

  // updates the matrix or queues the rotated vector
  task automatic predict_beat(input eulr_pkg::in_item_t b);
    longint sr, cr, sp, cp, sy, cy, acc;
    longint v[3];
    eulr_pkg::out_item_t r;
    logic signed [23:0] comp[3];
    if (b.kind == eulr_pkg::KIND_ANGLES) begin
      cordic_sin_cos(b.roll, sr, cr);
      cordic_sin_cos(b.pitch, sp, cp);
      cordic_sin_cos(b.yaw, sy, cy);
      matrix[0] = round_entry(cp * cy * 32768);
      matrix[1] = round_entry(cy * sr * sp - cr * sy * 32768);
      matrix[2] = round_entry(cr * cy * sp + sr * sy * 32768);
      matrix[3] = round_entry(cp * sy * 32768);
      matrix[4] = round_entry(sr * sp * sy + cr * cy * 32768);
      matrix[5] = round_entry(cr * sp * sy - cy * sr * 32768);
      matrix[6] = clip(-sp, -65536, 65535);
      matrix[7] = round_entry(cp * sr * 32768);
      matrix[8] = round_entry(cr * cp * 32768);
    end else begin
      v[0] = b.vec_x; v[1] = b.vec_y; v[2] = b.vec_z;
      r.saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += v[k] * matrix[i * 3 + k];
        acc = floor_shr(acc + 16384, 15);
        if (acc > 8388607) begin
          acc = 8388607; r.saturated = 1'b1;
        end else if (acc < -8388608) begin
          acc = -8388608; r.saturated = 1'b1;
        end
        comp[i] = acc[23:0];
      end
      r.rot_x = comp[0]; r.rot_y = comp[1]; r.rot_z = comp[2];
      expected_rotations.push_back(r);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_on) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // long receiver hold-off while the sender keeps offering beats
  initial begin
    wait (send_idle_pct == 46 && recv_stall_pct == 0);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (300) @(negedge clk);
    hold_on = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (cycle_count > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && !in_stall) predict_beat(in_data);
      if (out_valid && !out_stall) begin
        if (expected_rotations.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          eulr_pkg::out_item_t e;
          e = expected_rotations.pop_front();
          if (out_data.rot_x !== e.rot_x) begin
            $error("rot_x exp %0d got %0d", e.rot_x, out_data.rot_x); errors++;
          end
          if (out_data.rot_y !== e.rot_y) begin
            $error("rot_y exp %0d got %0d", e.rot_y, out_data.rot_y); errors++;
          end
          if (out_data.rot_z !== e.rot_z) begin
            $error("rot_z exp %0d got %0d", e.rot_z, out_data.rot_z); errors++;
          end
          if (out_data.saturated !== e.saturated) begin
            $error("saturated exp %0d got %0d", e.saturated, out_data.saturated);
            errors++;
          end
        end
      end
    end
  end

  function automatic eulr_pkg::in_item_t make_beat(logic k, int r, int p, int y, int vx,
                                                   int vy, int vz);
    eulr_pkg::in_item_t b;
    b.kind = k; b.roll = 16'(r); b.pitch = 16'(p); b.yaw = 16'(y);
    b.vec_x = 24'(vx); b.vec_y = 24'(vy); b.vec_z = 24'(vz);
    return b;
  endfunction

  function automatic int rand_angle();
    case ($urandom_range(3))
      0: return $signed(16'($urandom));
      1: return int'($urandom_range(51472)) - 25736;
      2: return int'($urandom_range(800)) - 400;
      default: return ($urandom_range(1) ? 12868 : -12868) + int'($urandom_range(8)) - 4;
    endcase
  endfunction

  function automatic int rand_vec();
    if ($urandom_range(3) == 0)
      return $urandom_range(1) ? 8388607 - int'($urandom_range(3)) : -8388608;
    return $signed(24'($urandom));
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid || expected_rotations.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    int idle_set[4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{34, 34}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // rotate before any angle load, then angle extremes and wrap cases
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ROTATE, 0, 0, 0, 8388607, -8388608,
      1234));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ANGLES, 0, 0, 0, -1, -1, -1));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ROTATE, -1, -1, -1, 8388607, -8388608,
      -1));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ANGLES, 32767, -32768, 25736, 0, 0, 0));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ROTATE, 0, 0, 0, 8388607, 8388607,
      8388607));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ANGLES, -25736, 25736, -32768, 0, 0, 0));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ROTATE, 0, 0, 0, -8388608, -8388608,
      -8388608));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ANGLES, 12868, 12869, -12869, 0, 0, 0));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ROTATE, 0, 0, 0, 8388607, -8388608,
      8388607));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ANGLES, 6434, -6434, 3217, 0, 0, 0));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ROTATE, 0, 0, 0, 8388607, 8388607,
      -8388608));
    pending_beats.push_back(make_beat(eulr_pkg::KIND_ROTATE, 0, 0, 0, 1, -1, 0));
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph][0];
      recv_stall_pct = idle_set[ph][1];
      for (int n = 0; n < 125; n++) begin
        logic k;
        k = ($urandom_range(2) == 0) ? eulr_pkg::KIND_ANGLES : eulr_pkg::KIND_ROTATE;
        pending_beats.push_back(make_beat(k, rand_angle(), rand_angle(), rand_angle(),
          rand_vec(), rand_vec(), rand_vec()));
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
